@@ rtl/nbrfp_pkg.sv @@
// Shared types and constants for the null-bitmap record field parser.
package nbrfp_pkg;

  localparam int MAX_ATTRIBUTES_DEF = 32;

  localparam int ATTR_COUNT_W = 6;
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_INDEX_W  = 1;
  localparam int VARCHAR_W    = 32;
  localparam int LEN_BYTES    = 4;

  localparam logic [CFG_INDEX_W-1:0] CFG_ATTR_COUNT   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_VARCHAR_MASK = 1'b1;

  localparam logic [1:0] ROLE_BITMAP  = 2'd0;
  localparam logic [1:0] ROLE_FIXED   = 2'd1;
  localparam logic [1:0] ROLE_PAYLOAD = 2'd2;

  typedef enum logic [1:0] {
    PH_BITMAP  = 2'd0,
    PH_FIXED   = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_t;

  typedef struct packed {
    logic [1:0]  byte_role;
    logic [4:0]  attr_index;
    logic        field_last;
    logic        record_last;
    logic [31:0] record_size;
  } out_t;

endpackage

@@ rtl/null_bitmap_record_field_parser_core.sv @@
// Null-bitmap record field parser: tags each record byte with its role and attribute.
//
// Takes one record byte per cycle and returns one tagged result per byte, in the
// cycle after acceptance, through a single output register. The input is
// stalled only while that register holds a result the downstream side is not
// taking, so the sustained rate is one byte per cycle. A record opens with
// ceil(n/8) null bitmap bytes (MSB of the first byte is attribute 0, set means
// null), followed by 4 bytes per non-null int/real attribute, or a 4-byte
// little-endian length plus payload per non-null varchar. The last byte of a
// record carries the saturating record size; restart forces a new record.
// Configuration writes take effect at once; null flags left unwritten since
// reset read as undefined.
module null_bitmap_record_field_parser_core #(
  parameter int MAX_ATTRIBUTES = nbrfp_pkg::MAX_ATTRIBUTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [nbrfp_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [nbrfp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  nbrfp_pkg::in_t                     in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output nbrfp_pkg::out_t                    out_data
);
  import nbrfp_pkg::*;

  localparam int AW = (MAX_ATTRIBUTES > 1) ? $clog2(MAX_ATTRIBUTES) : 1;
  localparam int NW = ATTR_COUNT_W + 1;

  // configuration
  logic [ATTR_COUNT_W-1:0] attr_count_r;
  logic [VARCHAR_W-1:0]    varchar_mask_r;

  // parse state
  phase_t                  phase_r,  phase_nxt;
  logic [AW-1:0]           cur_r,    cur_nxt;
  logic [31:0]             fbc_r,    fbc_nxt;
  logic [31:0]             strlen_r, strlen_nxt;
  logic [31:0]             size_r,   size_nxt;
  logic [MAX_ATTRIBUTES-1:0] flags_r, flags_nxt;

  logic out_valid_r;
  out_t out_data_r, out_data_nxt;

  logic                      accept;
  logic [NW-1:0]             n_eff;
  logic [3:0]                nbytes;
  logic [MAX_ATTRIBUTES-1:0] vc_ext;
  logic [MAX_ATTRIBUTES-1:0] cand;
  logic                      found;
  logic [AW-1:0]             first;

  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // effective attribute count clamped into 1..MAX_ATTRIBUTES
  always_comb begin
    if (attr_count_r == '0) begin
      n_eff = NW'(1);
    end else if (NW'(attr_count_r) > NW'(MAX_ATTRIBUTES)) begin
      n_eff = NW'(MAX_ATTRIBUTES);
    end else begin
      n_eff = NW'(attr_count_r);
    end
  end
  assign nbytes = 4'((n_eff + NW'(7)) >> 3);

  // attributes at index 32 and above are never varchar
  for (genvar g = 0; g < MAX_ATTRIBUTES; g++) begin : g_vc
    if (g < VARCHAR_W) begin : g_in
      assign vc_ext[g] = varchar_mask_r[g];
    end else begin : g_out
      assign vc_ext[g] = 1'b0;
    end
  end

  always_comb begin
    phase_t      ph_e;
    logic [AW-1:0] cur_e;
    logic [31:0] fbc_e;
    logic [31:0] strlen_e;
    logic [31:0] size_e;
    logic [31:0] fbc_inc;
    logic [31:0] strlen_acc;
    logic        do_adv;
    logic        adv_all;
    logic        flast;
    logic        rlast;
    logic [1:0]  role;
    logic [4:0]  idx;

    // restart clears the record position before the byte is parsed
    if (in_data.restart) begin
      ph_e     = PH_BITMAP;
      cur_e    = '0;
      fbc_e    = '0;
      strlen_e = '0;
      size_e   = '0;
    end else begin
      ph_e     = phase_r;
      cur_e    = cur_r;
      fbc_e    = fbc_r;
      strlen_e = strlen_r;
      size_e   = size_r;
    end

    if (size_e != '1) begin
      size_e = size_e + 32'd1;
    end

    fbc_inc    = fbc_e + 32'd1;
    strlen_acc = strlen_e | (32'(in_data.data_byte) << {fbc_e[1:0], 3'b000});

    phase_nxt  = ph_e;
    cur_nxt    = cur_e;
    fbc_nxt    = fbc_inc;
    strlen_nxt = strlen_e;
    size_nxt   = size_e;
    flags_nxt  = flags_r;
    do_adv     = 1'b0;
    adv_all    = 1'b0;
    flast      = 1'b0;
    role       = ROLE_BITMAP;
    idx        = 5'(cur_e);

    unique case (ph_e)
      PH_FIXED: begin
        role       = ROLE_FIXED;
        strlen_nxt = strlen_acc;
        if (fbc_inc >= 32'(LEN_BYTES)) begin
          if (vc_ext[cur_e] && strlen_acc != '0) begin
            phase_nxt = PH_PAYLOAD;
            fbc_nxt   = '0;
          end else begin
            flast  = 1'b1;
            do_adv = 1'b1;
          end
        end
      end
      PH_PAYLOAD: begin
        role = ROLE_PAYLOAD;
        if (fbc_inc >= strlen_e) begin
          flast  = 1'b1;
          do_adv = 1'b1;
        end
      end
      default: begin
        role = ROLE_BITMAP;
        idx  = 5'(fbc_e);
        for (int i = 0; i < MAX_ATTRIBUTES; i++) begin
          if (fbc_e[2:0] == 3'(i / 8) && NW'(i) < n_eff) begin
            flags_nxt[i] = in_data.data_byte[7 - (i % 8)];
          end
        end
        if (fbc_inc >= 32'(nbytes)) begin
          flast   = 1'b1;
          do_adv  = 1'b1;
          adv_all = 1'b1;
        end
      end
    endcase

    // first non-null attribute below n after the current one, or from attribute 0 when the bitmap ends
    for (int i = 0; i < MAX_ATTRIBUTES; i++) begin
      cand[i] = ~flags_nxt[i] && (NW'(i) < n_eff) && (adv_all || AW'(i) > cur_e);
    end
    found = 1'b0;
    first = '0;
    for (int i = MAX_ATTRIBUTES - 1; i >= 0; i--) begin
      if (cand[i]) begin
        found = 1'b1;
        first = AW'(i);
      end
    end

    rlast = 1'b0;
    if (do_adv) begin
      if (found) begin
        phase_nxt  = PH_FIXED;
        cur_nxt    = first;
        fbc_nxt    = '0;
        strlen_nxt = '0;
      end else begin
        rlast = 1'b1;
      end
    end

    if (rlast) begin
      phase_nxt  = PH_BITMAP;
      cur_nxt    = '0;
      fbc_nxt    = '0;
      strlen_nxt = '0;
      size_nxt   = '0;
    end

    out_data_nxt.byte_role   = role;
    out_data_nxt.attr_index  = idx;
    out_data_nxt.field_last  = flast;
    out_data_nxt.record_last = rlast;
    out_data_nxt.record_size = rlast ? size_e : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_count_r   <= ATTR_COUNT_W'(1);
      varchar_mask_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ATTR_COUNT:   attr_count_r   <= cfg_wdata[ATTR_COUNT_W-1:0];
        CFG_VARCHAR_MASK: varchar_mask_r <= cfg_wdata[VARCHAR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_BITMAP;
      cur_r       <= '0;
      fbc_r       <= '0;
      strlen_r    <= '0;
      size_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept | (out_valid_r & out_stall);
      if (accept) begin
        phase_r  <= phase_nxt;
        cur_r    <= cur_nxt;
        fbc_r    <= fbc_nxt;
        strlen_r <= strlen_nxt;
        size_r   <= size_nxt;
      end
    end
  end

  // null flags and the result payload carry no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      flags_r    <= flags_nxt;
      out_data_r <= out_data_nxt;
    end
  end

  a_size_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.record_last || out_data_r.record_size == '0))
    else $error("record_size set on a byte that does not end the record");

  a_last_closes_field: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.record_last) |-> out_data_r.field_last)
    else $error("record end without field end");

  a_payload_len: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (strlen_r != '0 && fbc_r < strlen_r))
    else $error("payload phase with exhausted string length");

  a_bitmap_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BITMAP) |-> (fbc_r < 32'(nbytes) || fbc_r < 32'd8))
    else $error("bitmap byte counter out of range");

  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && out_data_nxt.record_last) |=> (phase_r == PH_BITMAP && size_r == '0))
    else $error("record end did not return to bitmap phase");

endmodule

@@ tb/record_parse_checker.sv @@
// Checker for the record field parser: predicts every byte tag and compares it with the output.
module record_parse_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [nbrfp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [nbrfp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  nbrfp_pkg::in_t                   in_data,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  nbrfp_pkg::out_t                  out_data,
  output int                               fail_count,
  output int                               outstanding,
  output int                               bytes_checked,
  output int                               records_closed,
  output int                               payload_bytes
);
  import nbrfp_pkg::*;

  // Configuration copy
  logic [ATTR_COUNT_W-1:0] attr_cnt;
  logic [VARCHAR_W-1:0]    vc_mask;

  // Parser state
  phase_t      ph;
  logic [4:0]  cur_attr;
  logic [31:0] null_bits;
  logic [31:0] byte_cnt;
  logic [31:0] str_len;
  logic [31:0] rec_size;

  out_t expected_tags[$];
  out_t want;
  int   errs = 0;

  function automatic int active_attrs();
    if (attr_cnt == 0) return 1;
    if (attr_cnt > MAX_ATTRIBUTES_DEF) return MAX_ATTRIBUTES_DEF;
    return int'(attr_cnt);
  endfunction

  function automatic void clear_record();
    ph       = PH_BITMAP;
    cur_attr = '0;
    byte_cnt = '0;
    str_len  = '0;
    rec_size = '0;
  endfunction

  // Move to the first non-null attribute at or after start; 0 when the record is done.
  function automatic bit seek_attr(int start);
    for (int i = start; i < active_attrs(); i++) begin
      if (!null_bits[i]) begin
        cur_attr = 5'(i);
        ph       = PH_FIXED;
        byte_cnt = '0;
        str_len  = '0;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic out_t parse_byte(in_t x);
    out_t        r;
    int          n;
    logic [31:0] total;
    r = '0;
    if (x.restart) clear_record();
    n = active_attrs();
    if (rec_size != '1) rec_size++;
    total = rec_size;
    case (ph)
      PH_FIXED: begin
        r.byte_role  = ROLE_FIXED;
        r.attr_index = cur_attr;
        str_len = str_len | (32'(x.data_byte) << {byte_cnt[1:0], 3'b000});
        byte_cnt++;
        if (byte_cnt == LEN_BYTES) begin
          // type is judged by the mask at the last length byte
          if (vc_mask[cur_attr] && str_len != 0) begin
            ph       = PH_PAYLOAD;
            byte_cnt = '0;
          end else begin
            r.field_last  = 1'b1;
            r.record_last = !seek_attr(int'(cur_attr) + 1);
          end
        end
      end
      PH_PAYLOAD: begin
        r.byte_role  = ROLE_PAYLOAD;
        r.attr_index = cur_attr;
        byte_cnt++;
        if (byte_cnt >= str_len) begin
          r.field_last  = 1'b1;
          r.record_last = !seek_attr(int'(cur_attr) + 1);
        end
      end
      default: begin
        r.byte_role  = ROLE_BITMAP;
        r.attr_index = byte_cnt[4:0];
        for (int k = 0; k < 8; k++) begin
          if (byte_cnt * 8 + k < n) null_bits[byte_cnt * 8 + k] = x.data_byte[7 - k];
        end
        byte_cnt++;
        if (byte_cnt >= (n + 7) / 8) begin
          r.field_last  = 1'b1;
          r.record_last = !seek_attr(0);
        end
      end
    endcase
    if (r.record_last) begin
      r.record_size = total;
      clear_record();
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (act_val !== exp_val) begin
      errs++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, act_val);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      attr_cnt  = 6'd1;
      vc_mask   = '0;
      null_bits = '0;
      clear_record();
      expected_tags.delete();
    end else begin
      if (in_valid && !in_stall) expected_tags.insert(expected_tags.size(), parse_byte(in_data));
      if (out_valid && !out_stall) begin
        if (expected_tags.size() == 0) begin
          errs++;
          $display("%0t: unexpected transaction, expected none, got %0h", $time, out_data);
        end else begin
          want = expected_tags.pop_front();
          check_field("byte_role", want.byte_role, out_data.byte_role);
          check_field("attr_index", want.attr_index, out_data.attr_index);
          check_field("field_last", want.field_last, out_data.field_last);
          check_field("record_last", want.record_last, out_data.record_last);
          check_field("record_size", want.record_size, out_data.record_size);
          bytes_checked <= bytes_checked + 1;
          if (want.record_last) records_closed <= records_closed + 1;
          if (want.byte_role == ROLE_PAYLOAD) payload_bytes <= payload_bytes + 1;
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_ATTR_COUNT) attr_cnt = cfg_wdata[ATTR_COUNT_W-1:0];
        else vc_mask = cfg_wdata[VARCHAR_W-1:0];
      end
    end
    outstanding <= expected_tags.size();
    fail_count  <= errs;
  end

endmodule

@@ tb/testbench.sv @@
// Top of the parser testbench: clock, reset, record stimulus, flow control and verdict.
module testbench;
  import nbrfp_pkg::*;

  localparam int IDLE_PCT    = 32;
  localparam int PHASES      = 14;
  localparam int PHASE_BYTES = 45;
  localparam int HOLD_OFF    = 300;
  localparam int CYCLE_LIMIT = 200000;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  logic                   in_valid;
  logic                   in_stall;
  in_t                    in_data;
  logic                   out_valid;
  logic                   out_stall;
  out_t                   out_data;

  int fail_count;
  int outstanding;
  int bytes_checked;
  int records_closed;
  int payload_bytes;

  logic [ATTR_COUNT_W-1:0] cfg_count;
  logic [VARCHAR_W-1:0]    cfg_mask;
  bit quiet        = 1'b0;
  int hold_cycles  = 0;
  int bytes_sent   = 0;
  int phase_end    = 0;
  bit rec_open     = 1'b0;
  int settings_cnt = 0;
  int cycle_cnt    = 0;

  null_bitmap_record_field_parser_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  record_parse_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .fail_count     (fail_count),
    .outstanding    (outstanding),
    .bytes_checked  (bytes_checked),
    .records_closed (records_closed),
    .payload_bytes  (payload_bytes)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[null_bitmap_record_field_parser_core] ERROR");
      $finish;
    end
  end

  // Receiver: random stalls, none while quiet, and a long hold-off on request.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  task automatic send_byte(input logic [7:0] d, input logic rs);
    if (!quiet) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: d, restart: rs};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // Drop valid and wait until every transaction has come back.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input logic [ATTR_COUNT_W-1:0] cnt,
                              input logic [VARCHAR_W-1:0] mask);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ATTR_COUNT;
    cfg_wdata <= CFG_DATA_W'(cnt);
    @(posedge clk);
    cfg_index <= CFG_VARCHAR_MASK;
    cfg_wdata <= mask;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    cfg_count = cnt;
    cfg_mask  = mask;
    settings_cnt++;
  endtask

  // One well-formed record with random content, sometimes cut short.
  task automatic send_record();
    logic [7:0]  rec_bytes[$];
    logic [31:0] nulls;
    logic [31:0] slen;
    logic [7:0]  bm;
    int          n;
    int          dens;
    int          sel;
    int          cut;
    int          sent;
    bit          restart_first;
    bit          broken;
    n = (cfg_count == 0) ? 1 : ((cfg_count > 32) ? 32 : int'(cfg_count));
    sel = $urandom_range(19);
    dens = (sel == 0) ? 100 : ((sel < 5) ? 0 : 30);
    for (int a = 0; a < 32; a++) nulls[a] = ($urandom_range(99) < dens);
    for (int b = 0; b < (n + 7) / 8; b++) begin
      bm = 8'($urandom);
      for (int k = 0; k < 8; k++) begin
        if (b * 8 + k < n) bm[7 - k] = nulls[b * 8 + k];
      end
      rec_bytes.insert(rec_bytes.size(), bm);
    end
    broken = 1'b0;
    for (int a = 0; a < n && !broken; a++) begin
      if (!nulls[a]) begin
        if (cfg_mask[a]) begin
          sel = $urandom_range(99);
          if (sel < 15) slen = 0;
          else if (sel < 80) slen = $urandom_range(1, 8);
          else if (sel < 95) slen = $urandom_range(9, 48);
          else slen = $urandom | 32'h100;
          for (int k = 0; k < 4; k++) rec_bytes.insert(rec_bytes.size(), slen[8 * k +: 8]);
          for (int k = 0; k < slen && k < 48; k++) begin
            rec_bytes.insert(rec_bytes.size(), 8'($urandom));
          end
          // a huge length cannot be finished; leave the record open
          if (slen > 48) broken = 1'b1;
        end else begin
          repeat (4) rec_bytes.insert(rec_bytes.size(), 8'($urandom));
        end
      end
    end
    if ($urandom_range(9) == 0) broken = 1'b1;
    cut = broken ? $urandom_range(1, rec_bytes.size()) : rec_bytes.size();
    restart_first = rec_open ? ($urandom_range(9) != 0) : 1'($urandom_range(1));
    sent = 0;
    while (sent < cut && bytes_sent < phase_end) begin
      send_byte(rec_bytes[sent], (sent == 0) ? restart_first : 1'b0);
      sent++;
    end
    rec_open = broken || (sent < rec_bytes.size());
  endtask

  initial begin
    logic [ATTR_COUNT_W-1:0] cnt;
    logic [VARCHAR_W-1:0]    mask;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_ATTR_COUNT;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Count above the maximum, all attributes null: fills every null flag.
    program_regs(6'd63, '0);
    phase_end = 1 << 30;
    send_byte(8'hFF, 1'b1);
    repeat (3) send_byte(8'hFF, 1'b0);

    // Count of zero acts as one; attribute 0 is a string.
    program_regs(6'd0, '1);
    send_byte(8'h00, 1'b1);
    repeat (4) send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h02, 1'b0);
    repeat (3) send_byte(8'h00, 1'b0);
    send_byte(8'hAB, 1'b0);
    send_byte(8'hCD, 1'b0);
    send_byte(8'h80, 1'b0);
    // restart in the middle of a length field
    send_byte(8'h00, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: cnt = 6'd0;
        1: cnt = 6'd63;
        2: cnt = 6'd32;
        3: cnt = 6'd8;
        4: cnt = 6'd9;
        5: cnt = 6'd1;
        default: begin
          if ($urandom_range(3) == 0) cnt = 6'($urandom_range(11, 40));
          else cnt = 6'($urandom_range(1, 10));
        end
      endcase
      if (p % 4 == 0) mask = '0;
      else if (p % 4 == 1) mask = '1;
      else mask = $urandom;
      program_regs(cnt, mask);
      quiet = (p == 3);
      if (p == 6) hold_cycles = HOLD_OFF;
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) begin
        if ($urandom_range(9) == 0) begin
          repeat ($urandom_range(1, 12)) begin
            if (bytes_sent < phase_end) send_byte(8'($urandom), $urandom_range(99) < 15);
          end
          rec_open = 1'b1;
        end else begin
          send_record();
        end
      end
    end

    settle();
    repeat (8) @(posedge clk);
    $display("Parsed %0d bytes through %0d register settings; %0d records closed,",
             bytes_checked, settings_cnt, records_closed);
    $display("%0d string payload bytes seen, with restarts and cut-short records mixed in.",
             payload_bytes);
    if (fail_count == 0 && outstanding == 0) begin
      $display("[null_bitmap_record_field_parser_core] OK");
    end else begin
      $display("[null_bitmap_record_field_parser_core] ERROR");
    end
    $finish;
  end

endmodule

@@ null_bitmap_record_field_parser_core.f @@
rtl/nbrfp_pkg.sv
rtl/null_bitmap_record_field_parser_core.sv
tb/record_parse_checker.sv
tb/testbench.sv
